// ===== src/brfo_pkg.sv =====
// Shared types and constants for the circular byte FIFO with overwrite.
`default_nettype none

package brfo_pkg;

    // Default number of entries in the byte store.
    localparam int DEPTH_DEFAULT = 1024;
    // Capacity register width and its value after reset.
    localparam int CFG_W         = 11;
    localparam int CAP_RESET     = 1024;
    // Width of the reported fill level.
    localparam int FILL_W        = 11;

    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_PUSH_OVR = 2'd1,
        OP_POP      = 2'd2,
        OP_FLUSH    = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic [7:0]        read_data;
        logic [FILL_W-1:0] fill_level;
        logic              is_full;
        logic              is_empty;
    } t_out_item;

    // Result fields known at accept time; the popped byte follows from memory.
    typedef struct packed {
        logic              accepted;
        logic              popped;
        logic [FILL_W-1:0] fill_level;
        logic              is_full;
        logic              is_empty;
    } t_meta;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] wr_data;
    } t_mem_cmd;

endpackage

`default_nettype wire

// ===== src/brfo_store.sv =====
// Byte store: one write port, one read port with registered read data.
`default_nettype none

module brfo_store #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                 i_clk,
    input  brfo_pkg::t_mem_cmd  i_cmd,
    input  wire  [AW-1:0]       i_wr_addr,
    input  wire  [AW-1:0]       i_rd_addr,
    output logic [7:0]          o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_cmd.wr_data;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== src/brfo_ctrl.sv =====
// Position and flag control: capacity register, write/read positions, full flag.
`default_nettype none

module brfo_ctrl #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int LW    = $clog2(DEPTH + 1)
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_wr_en,
    input  wire  [brfo_pkg::CFG_W-1:0]      i_cfg_wr_data,
    input  wire                             i_accept,
    input  brfo_pkg::t_in_item              i_item,
    output brfo_pkg::t_mem_cmd              o_mem_cmd,
    output logic [AW-1:0]                   o_wr_addr,
    output logic [AW-1:0]                   o_rd_addr,
    output brfo_pkg::t_meta                 o_meta
);

    localparam int CAP_INIT = (brfo_pkg::CAP_RESET > DEPTH) ? DEPTH : brfo_pkg::CAP_RESET;

    logic [LW-1:0] r_cap;
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic          r_ff;

    logic [LW-1:0] n_cap;
    logic [AW-1:0] n_wp;
    logic [AW-1:0] n_rp;
    logic          n_ff;

    logic [LW-1:0] wp_plus;
    logic [LW-1:0] rp_plus;
    logic [AW-1:0] wp_inc;
    logic [AW-1:0] rp_inc;
    logic          pos_eq;
    logic          cur_full;
    logic          cur_empty;
    logic          acc;
    logic          pop;
    logic          wr;
    logic          n_eq;
    logic [LW-1:0] level;

    // Clamp the written capacity into 1..DEPTH.
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            n_cap = LW'(1);
        end else if (32'(i_cfg_wr_data) > 32'(DEPTH)) begin
            n_cap = LW'(DEPTH);
        end else begin
            n_cap = LW'(i_cfg_wr_data);
        end
    end

    // Advance a position, wrapping at capacity.
    assign wp_plus = LW'(r_wp) + LW'(1);
    assign rp_plus = LW'(r_rp) + LW'(1);
    assign wp_inc  = (wp_plus >= r_cap) ? '0 : AW'(wp_plus);
    assign rp_inc  = (rp_plus >= r_cap) ? '0 : AW'(rp_plus);

    assign pos_eq    = (r_wp == r_rp);
    assign cur_full  = r_ff & pos_eq;
    assign cur_empty = ~r_ff & pos_eq;

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        n_ff = r_ff;
        acc  = 1'b0;
        pop  = 1'b0;
        wr   = 1'b0;
        unique case (i_item.op)
            brfo_pkg::OP_PUSH: begin
                if (!cur_full) begin
                    wr   = 1'b1;
                    acc  = 1'b1;
                    n_wp = wp_inc;
                    if (wp_inc == r_rp) begin
                        n_ff = 1'b1;
                    end
                end
            end
            brfo_pkg::OP_PUSH_OVR: begin
                // Drop the oldest byte when the store wraps onto it.
                wr   = 1'b1;
                acc  = 1'b1;
                n_wp = wp_inc;
                if (cur_full || wp_inc == r_rp) begin
                    n_ff = 1'b1;
                    n_rp = wp_inc;
                end
            end
            brfo_pkg::OP_POP: begin
                if (!cur_empty) begin
                    pop  = 1'b1;
                    acc  = 1'b1;
                    n_rp = rp_inc;
                    n_ff = 1'b0;
                end
            end
            brfo_pkg::OP_FLUSH: begin
                n_ff = 1'b0;
                n_rp = r_wp;
            end
        endcase
    end

    // Fill level after the item; modular arithmetic in LW bits is exact here.
    assign n_eq = (n_wp == n_rp);
    always_comb begin
        if (n_ff) begin
            level = r_cap;
        end else if (n_wp >= n_rp) begin
            level = LW'(n_wp) - LW'(n_rp);
        end else begin
            level = LW'(n_wp) + r_cap - LW'(n_rp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= LW'(CAP_INIT);
            r_wp  <= '0;
            r_rp  <= '0;
            r_ff  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_cap <= n_cap;
            r_wp  <= '0;
            r_rp  <= '0;
            r_ff  <= 1'b0;
        end else if (i_accept) begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_ff <= n_ff;
        end
    end

    assign o_mem_cmd.wr_en   = i_accept & wr;
    assign o_mem_cmd.rd_en   = i_accept & pop;
    assign o_mem_cmd.wr_data = i_item.data;
    assign o_wr_addr         = r_wp;
    assign o_rd_addr         = r_rp;

    assign o_meta.accepted   = acc;
    assign o_meta.popped     = pop;
    assign o_meta.fill_level = brfo_pkg::FILL_W'(level);
    assign o_meta.is_full    = n_ff & n_eq;
    assign o_meta.is_empty   = ~n_ff & n_eq;

    a_wp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_wp) < r_cap)
        else $error("write position beyond capacity");

    a_rp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_rp) < r_cap)
        else $error("read position beyond capacity");

    a_full_at_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ff |-> (r_wp == r_rp))
        else $error("full flag set while positions differ");

    a_cfg_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> (r_wp == '0 && r_rp == '0 && !r_ff))
        else $error("capacity write did not empty the FIFO");

endmodule

`default_nettype wire

// ===== src/byte_ring_fifo_overwrite_core.sv =====
// Top level of the circular byte FIFO with overwrite.
`default_nettype none

// Byte FIFO over a circular store of DEPTH bytes that wraps at the capacity
// register (values clamp to 1..DEPTH; a write also empties the FIFO, so write
// it only while idle). Each item is one byte operation: checked push,
// overwriting push (drops the oldest byte when full), pop, or flush, and
// each item yields exactly one result with the accepted flag, popped byte,
// fill level and full/empty flags. The block takes one item per cycle
// when the output is not stalled. An accepted item passes through the read
// stage, where the synchronous read of the byte store returns the popped
// byte, and then the output register. Positions and flags update at the
// accepting edge, so back-to-back pushes and pops need no interlock.
// The byte store has no reset; the FIFO never pops an entry it did not write.
module byte_ring_fifo_overwrite_core #(
    parameter int DEPTH = brfo_pkg::DEPTH_DEFAULT
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire  [brfo_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  brfo_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output brfo_pkg::t_out_item         o_out_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    brfo_pkg::t_mem_cmd mem_cmd;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [7:0]         rd_data;
    brfo_pkg::t_meta    meta;

    // Read stage: item whose byte is coming out of the store.
    logic               r_a_valid;
    brfo_pkg::t_meta    r_a_meta;
    // Output register.
    logic               r_o_valid;
    brfo_pkg::t_out_item r_o_item;

    logic               in_accept;
    logic               a_move;
    brfo_pkg::t_out_item n_o_item;

    // Advance the read stage when the output register is empty or draining.
    assign a_move     = r_a_valid & (~r_o_valid | ~i_out_stall);
    assign o_in_stall = r_a_valid & ~a_move;
    assign in_accept  = i_in_valid & ~o_in_stall;

    brfo_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .LW    (LW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_item        (i_in_item),
        .o_mem_cmd     (mem_cmd),
        .o_wr_addr     (wr_addr),
        .o_rd_addr     (rd_addr),
        .o_meta        (meta)
    );

    brfo_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Merge the popped byte; report zero when nothing was popped.
    always_comb begin
        n_o_item.accepted   = r_a_meta.accepted;
        n_o_item.read_data  = r_a_meta.popped ? rd_data : 8'd0;
        n_o_item.fill_level = r_a_meta.fill_level;
        n_o_item.is_full    = r_a_meta.is_full;
        n_o_item.is_empty   = r_a_meta.is_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_meta <= meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_move) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_o_item <= n_o_item;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_a_valid)
        else $error("accepted item did not reach the read stage");

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_a_valid && r_o_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_stage_moves_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_move |=> r_o_valid)
        else $error("read stage advanced without filling the output");

endmodule

`default_nettype wire
